@@ rtl/ssum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssum_pkg
// Shared types and codes for the sorted set union merge core.
// ----------------------------------------------------------------------------
package ssum_pkg;

    // Request command codes
    localparam logic [1:0] CMD_APPEND_A = 2'd0;
    localparam logic [1:0] CMD_APPEND_B = 2'd1;
    localparam logic [1:0] CMD_MERGE    = 2'd2;

    // Width of the emitted union value
    localparam int OUT_WIDTH = 32;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_PICK = 3'b100
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic append_a;
        logic append_b;
        logic rd_en;
        logic emit;
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic pick_last;
    } dp_status_t;

endpackage

@@ rtl/ssum_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssum_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssum_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ssum_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssum_ctrl
// Controller: takes requests and sequences the merge read/pick steps.
// ----------------------------------------------------------------------------
module ssum_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  ssum_pkg::dp_status_t  status,
    output ssum_pkg::ctrl_cmd_t   ctrl
);

    ssum_pkg::state_t state_reg;
    ssum_pkg::state_t state_next;
    logic             accept;

    // Take requests only between merges
    assign in_stall = (state_reg != ssum_pkg::ST_IDLE);
    assign accept   = in_valid && (state_reg == ssum_pkg::ST_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        ctrl.append_a = 1'b0;
        ctrl.append_b = 1'b0;
        ctrl.rd_en    = 1'b0;
        ctrl.emit     = 1'b0;
        case (state_reg)
            ssum_pkg::ST_IDLE:
            begin
                ctrl.append_a = accept && (cmd == ssum_pkg::CMD_APPEND_A);
                ctrl.append_b = accept && (cmd == ssum_pkg::CMD_APPEND_B);
                if (accept && (cmd == ssum_pkg::CMD_MERGE))
                begin
                    state_next = ssum_pkg::ST_READ;
                end
            end
            ssum_pkg::ST_READ:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ssum_pkg::ST_PICK;
            end
            ssum_pkg::ST_PICK:
            begin
                // Hold until the output register can take the result
                if (status.out_free)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = status.pick_last ? ssum_pkg::ST_IDLE
                                                  : ssum_pkg::ST_READ;
                end
            end
            default:
            begin
                state_next = ssum_pkg::ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssum_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ssum_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssum_datapath
// Datapath: set stores, fill counts, merge indices, compare and output stage.
// ----------------------------------------------------------------------------
module ssum_datapath #(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ssum_pkg::ctrl_cmd_t               ctrl,
    output ssum_pkg::dp_status_t              status,
    input  logic signed [31:0]                value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [ssum_pkg::OUT_WIDTH-1:0] union_value,
    output logic                              last,
    output logic                              empty_union,
    output logic                              overflow
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]          count_a_reg, count_b_reg;
    logic [CW-1:0]          idx_a_reg, idx_b_reg;
    logic [CW-1:0]          idx_a_next, idx_b_next;
    logic                   overflow_reg;
    logic                   full_a, full_b;
    logic                   wr_a, wr_b;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic signed [63:0]     value_sx;
    logic [VALUE_WIDTH-1:0] rd_a, rd_b;
    logic                   avail_a, avail_b;
    logic                   take_a, take_b;
    logic                   pick_empty;
    logic [VALUE_WIDTH-1:0] pick_value;
    logic [63:0]            pick_ext;
    logic                   out_valid_reg;
    logic [ssum_pkg::OUT_WIDTH-1:0] union_value_reg;
    logic                   last_reg, empty_reg, overflow_out_reg;

    // Sign-extend the request value to the stored width
    assign value_sx = 64'(value);
    assign wr_data  = value_sx[VALUE_WIDTH-1:0];

    // Drop appends to a full set
    assign full_a = (count_a_reg == CW'(DEPTH));
    assign full_b = (count_b_reg == CW'(DEPTH));
    assign wr_a   = ctrl.append_a && !full_a;
    assign wr_b   = ctrl.append_b && !full_b;

    ssum_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (count_a_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (idx_a_reg[AW-1:0]),
        .rd_data (rd_a)
    );

    ssum_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (count_b_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (idx_b_reg[AW-1:0]),
        .rd_data (rd_b)
    );

    // Pick the smaller head; equal heads advance both and emit one copy
    always_comb
    begin
        avail_a = (idx_a_reg < count_a_reg);
        avail_b = (idx_b_reg < count_b_reg);
        take_a  = 1'b0;
        take_b  = 1'b0;
        if (avail_a && avail_b)
        begin
            if ($signed(rd_a) < $signed(rd_b))
            begin
                take_a = 1'b1;
            end
            else if ($signed(rd_b) < $signed(rd_a))
            begin
                take_b = 1'b1;
            end
            else
            begin
                take_a = 1'b1;
                take_b = 1'b1;
            end
        end
        else
        begin
            take_a = avail_a;
            take_b = avail_b;
        end
        pick_empty = !avail_a && !avail_b;
        pick_value = take_a ? rd_a : (take_b ? rd_b : '0);
        idx_a_next = idx_a_reg + CW'(take_a);
        idx_b_next = idx_b_reg + CW'(take_b);
    end

    // Zero-extend or truncate the picked value to the output width
    always_comb
    begin
        pick_ext                 = '0;
        pick_ext[VALUE_WIDTH-1:0] = pick_value;
    end

    assign status.pick_last = (idx_a_next >= count_a_reg) && (idx_b_next >= count_b_reg);
    assign status.out_free  = !out_valid_reg || !out_stall;

    // Counts, indices and sticky overflow; clear all on the last result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg  <= '0;
            count_b_reg  <= '0;
            idx_a_reg    <= '0;
            idx_b_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            if (status.pick_last)
            begin
                count_a_reg  <= '0;
                count_b_reg  <= '0;
                idx_a_reg    <= '0;
                idx_b_reg    <= '0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                idx_a_reg <= idx_a_next;
                idx_b_reg <= idx_b_next;
            end
        end
        else
        begin
            if (wr_a)
            begin
                count_a_reg <= count_a_reg + CW'(1);
            end
            if (wr_b)
            begin
                count_b_reg <= count_b_reg + CW'(1);
            end
            if ((ctrl.append_a && full_a) || (ctrl.append_b && full_b))
            begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            union_value_reg  <= pick_ext[ssum_pkg::OUT_WIDTH-1:0];
            last_reg         <= status.pick_last;
            empty_reg        <= pick_empty;
            overflow_out_reg <= overflow_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign union_value = union_value_reg;
    assign last        = last_reg;
    assign empty_union = empty_reg;
    assign overflow    = overflow_out_reg;

endmodule

@@ rtl/sorted_set_union_merge_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_union_merge_core
// Loads two ascending sets and emits their ascending union on request.
// ----------------------------------------------------------------------------
// An append request (cmd 0 for set A, cmd 1 for set B) gives no result;
// appends to a full set are dropped and raise the overflow flag. A merge
// request (cmd 2) stalls the input until its last result is loaded; an
// empty union gives a single result. Each result takes a registered read
// of both set stores, then a compare of the heads that loads the output
// register. Downstream stall holds the merge in the compare step. The last
// result clears both counts and the overflow flag; appends are taken again
// while that result waits to be taken.
// ----------------------------------------------------------------------------
module sorted_set_union_merge_core #(
    parameter int DEPTH       = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  union_value,
    output logic                last,
    output logic                empty_union,
    output logic                overflow
);

    ssum_pkg::ctrl_cmd_t  ctrl;
    ssum_pkg::dp_status_t status;

    ssum_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status),
        .ctrl     (ctrl)
    );

    ssum_datapath #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .union_value (union_value),
        .last        (last),
        .empty_union (empty_union),
        .overflow    (overflow)
    );

endmodule

@@ sim/sorted_set_union_merge_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_set_union_merge_core_tb
// Self-checking bench for the sorted set union merge core.
// ----------------------------------------------------------------------------
// Loads sets A and B through append requests and fires merge requests. The
// bench keeps its own copy of both sets and the sticky overflow flag, builds
// the union run of every merge as the request is taken, and compares each
// result the core hands out against the oldest union element still due.
// Directed corners come first; random set pairs follow, with random gaps on
// the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module sorted_set_union_merge_core_tb;

    localparam int         SET_DEPTH       = 32;
    localparam int         CLK_HALF        = 10;
    localparam int         RESET_CYCLES    = 12;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         TAIL_CYCLES     = 20;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam int         RANDOM_REQUESTS = 80;
    localparam logic [1:0] CMD_UNUSED      = 2'd3;

    // One element of a union run
    typedef struct packed {
        logic signed [31:0] value;
        logic               last;
        logic               empty;
        logic               ovf;
    } union_elem_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd       = ssum_pkg::CMD_APPEND_A;
    logic signed [31:0] value     = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] union_value;
    logic               last;
    logic               empty_union;
    logic               overflow;

    // Shadow of the core's sets and the union elements still due
    logic signed [31:0] set_a_q[$];
    logic signed [31:0] set_b_q[$];
    logic               set_ovf = 1'b0;
    union_elem_t        union_due_q[$];

    int unsigned n_errors     = 0;
    int unsigned n_requests   = 0;
    int unsigned n_merges     = 0;
    int unsigned n_ovf_merges = 0;
    int unsigned n_results    = 0;
    int unsigned n_cycles     = 0;
    bit          tx_idle_en   = 1'b1;
    bit          hold_active  = 1'b0;
    int          rx_run       = 0;
    event        hold_off_ev;

    sorted_set_union_merge_core #(
        .DEPTH       (SET_DEPTH),
        .VALUE_WIDTH (32)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .union_value (union_value),
        .last        (last),
        .empty_union (empty_union),
        .overflow    (overflow)
    );

    // Clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d union elements still due", $time, union_due_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Append one element to the union run being built
    function automatic void queue_union_elem(logic signed [31:0] v);
        union_elem_t e;
        e.value = v;
        e.last  = 1'b0;
        e.empty = 1'b0;
        e.ovf   = set_ovf;
        union_due_q.push_back(e);
    endfunction

    // Update the shadow sets for one taken request; a merge queues its run
    function automatic void apply_request(logic [1:0] c, logic signed [31:0] v);
        union_elem_t e;
        int i = 0;
        int j = 0;
        case (c)
            ssum_pkg::CMD_APPEND_A:
                if (set_a_q.size() < SET_DEPTH)
                    set_a_q.push_back(v);
                else
                    set_ovf = 1'b1;
            ssum_pkg::CMD_APPEND_B:
                if (set_b_q.size() < SET_DEPTH)
                    set_b_q.push_back(v);
                else
                    set_ovf = 1'b1;
            ssum_pkg::CMD_MERGE:
            begin
                n_merges++;
                if (set_ovf)
                    n_ovf_merges++;
                if (set_a_q.size() == 0 && set_b_q.size() == 0)
                begin
                    e.value = '0;
                    e.last  = 1'b1;
                    e.empty = 1'b1;
                    e.ovf   = set_ovf;
                    union_due_q.push_back(e);
                end
                else
                begin
                    // Walk both heads; equal heads give one element
                    while (i < set_a_q.size() && j < set_b_q.size())
                    begin
                        if (set_a_q[i] < set_b_q[j])
                        begin
                            queue_union_elem(set_a_q[i]);
                            i++;
                        end
                        else if (set_b_q[j] < set_a_q[i])
                        begin
                            queue_union_elem(set_b_q[j]);
                            j++;
                        end
                        else
                        begin
                            queue_union_elem(set_a_q[i]);
                            i++;
                            j++;
                        end
                    end
                    while (j < set_b_q.size())
                    begin
                        queue_union_elem(set_b_q[j]);
                        j++;
                    end
                    while (i < set_a_q.size())
                    begin
                        queue_union_elem(set_a_q[i]);
                        i++;
                    end
                    union_due_q[union_due_q.size() - 1].last = 1'b1;
                end
                set_a_q.delete();
                set_b_q.delete();
                set_ovf = 1'b0;
            end
            default:
                ;
        endcase
    endfunction

    // Request-side gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 30);
    endfunction

    // Offer one request, hold it until taken, then maybe idle
    task automatic send_request(input logic [1:0] c, input logic signed [31:0] v);
        int gap;
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        apply_request(c, v);
        if (c != CMD_UNUSED)
            n_requests++;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every due union element has come out
    task automatic wait_union_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (union_due_q.size() != 0)
            @(posedge clk);
    endtask

    // Long output hold-off, counted on the falling edge
    always
    begin
        @(hold_off_ev);
        @(negedge clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_active = 1'b0;
    end

    // Result-side stall: alternate free and stalled runs of random length
    always @(posedge clk)
    begin
        if (hold_active)
            out_stall <= 1'b1;
        else if (rx_run != 0)
            rx_run <= rx_run - 1;
        else if (out_stall)
        begin
            out_stall <= 1'b0;
            rx_run    <= ($urandom_range(0, 5) == 0) ? $urandom_range(20, 80)
                                                      : $urandom_range(0, 4);
        end
        else
        begin
            out_stall <= 1'b1;
            rx_run    <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(0, 2);
        end
    end

    // Compare every taken result with the oldest due union element
    always @(posedge clk)
    begin : union_check
        union_elem_t got;
        union_elem_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {union_value, last, empty_union, overflow};
            if (union_due_q.size() == 0)
            begin
                $display("%0t: unexpected result value=%0d last=%b empty=%b overflow=%b",
                         $time, got.value, got.last, got.empty, got.ovf);
                n_errors++;
            end
            else
            begin
                want = union_due_q.pop_front();
                // value carries no meaning on an empty union
                if (want.empty)
                    got.value = want.value;
                if (got !== want)
                begin
                    $display("%0t: mismatch expected value=%0d last=%b empty=%b overflow=%b",
                             $time, want.value, want.last, want.empty, want.ovf);
                    $display("%0t:          actual   value=%0d last=%b empty=%b overflow=%b",
                             $time, got.value, got.last, got.empty, got.ovf);
                    n_errors++;
                end
                n_results++;
            end
        end
    end

    // Merge with nothing loaded, and an unused command in between
    task automatic test_empty_merge();
        send_request(ssum_pkg::CMD_MERGE, $urandom);
        send_request(CMD_UNUSED, 32'h5A5A_A5A5);
        send_request(ssum_pkg::CMD_MERGE, '0);
        wait_union_drained();
    endtask

    // Extremes of the value range, shared extremes collapse to one element
    task automatic test_value_extremes();
        send_request(ssum_pkg::CMD_APPEND_A, 32'sh8000_0000);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sh8000_0000);
        send_request(ssum_pkg::CMD_APPEND_A, -32'sd1);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sd1);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd0);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sh7FFF_FFFF);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sh7FFF_FFFF);
        send_request(ssum_pkg::CMD_MERGE, '0);
        wait_union_drained();
    endtask

    // Only one set loaded
    task automatic test_one_sided();
        send_request(ssum_pkg::CMD_APPEND_A, -32'sd20);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd3);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd44);
        send_request(ssum_pkg::CMD_MERGE, '0);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sd7);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sd1000);
        send_request(ssum_pkg::CMD_MERGE, '0);
        wait_union_drained();
    endtask

    // Duplicates inside a set pass through; an unsorted set still merges
    task automatic test_duplicates_unsorted();
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd5);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd5);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd9);
        send_request(ssum_pkg::CMD_APPEND_B, 32'sd9);
        send_request(ssum_pkg::CMD_APPEND_B, -32'sd3);
        send_request(ssum_pkg::CMD_MERGE, '0);
        wait_union_drained();
    endtask

    // Fill both sets past full while results are held off for a long stretch
    task automatic test_full_sets_under_hold();
        int qa[$];
        int qb[$];
        tx_idle_en = 1'b0;
        repeat (SET_DEPTH + 1) qa.push_back(int'($urandom));
        repeat (SET_DEPTH + 2) qb.push_back(int'($urandom));
        qa.sort();
        qb.sort();
        -> hold_off_ev;
        foreach (qa[k])
            send_request(ssum_pkg::CMD_APPEND_A, qa[k]);
        foreach (qb[k])
            send_request(ssum_pkg::CMD_APPEND_B, qb[k]);
        send_request(ssum_pkg::CMD_MERGE, '0);
        // keep offering while the merge is stuck behind the hold
        send_request(ssum_pkg::CMD_APPEND_B, 32'sd12);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd12);
        send_request(ssum_pkg::CMD_APPEND_A, 32'sd40);
        send_request(ssum_pkg::CMD_MERGE, '0);
        send_request(ssum_pkg::CMD_MERGE, '0);
        wait_union_drained();
        tx_idle_en = 1'b1;
    endtask

    // Random set pairs, mostly sorted, with noise requests mixed in
    task automatic test_random_runs();
        int qa[$];
        int qb[$];
        int na;
        int nb;
        int t;
        int sent = 0;
        bit narrow;
        while (sent < RANDOM_REQUESTS)
        begin
            na = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 6);
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 6);
            narrow = ($urandom_range(0, 2) == 0);
            qa.delete();
            qb.delete();
            repeat (na) qa.push_back(narrow ? int'($urandom_range(0, 12)) - 6 : int'($urandom));
            repeat (nb) qb.push_back(narrow ? int'($urandom_range(0, 12)) - 6 : int'($urandom));
            qa.sort();
            qb.sort();
            // now and then break the ordering of a set
            if ($urandom_range(0, 7) == 0 && na > 1)
            begin
                t         = qa[0];
                qa[0]     = qa[na - 1];
                qa[na - 1] = t;
            end
            tx_idle_en = ($urandom_range(0, 3) != 0);
            while (qa.size() != 0 || qb.size() != 0)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_request(CMD_UNUSED, $urandom);
                if (qb.size() == 0 || (qa.size() != 0 && $urandom_range(0, 1) == 0))
                    send_request(ssum_pkg::CMD_APPEND_A, qa.pop_front());
                else
                    send_request(ssum_pkg::CMD_APPEND_B, qb.pop_front());
            end
            send_request(ssum_pkg::CMD_MERGE, $urandom);
            sent += na + nb + 1;
        end
        tx_idle_en = 1'b1;
        wait_union_drained();
    endtask

    // Test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_merge();
        test_value_extremes();
        test_one_sided();
        test_duplicates_unsorted();
        test_full_sets_under_hold();
        test_random_runs();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d requests, %0d merges (%0d with dropped appends), %0d results.",
                 n_requests, n_merges, n_ovf_merges, n_results);
        $display("%s%s", "Corners hit: empty union, value extremes, one-sided, duplicates, ",
                 "unsorted sets, full sets behind a long output hold.");
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
